### sv/jsse_pkg.sv
// Package: sizes, types and opcodes shared by the schedule evaluator files.
package jsse_pkg;

  localparam int MAX_JOBS        = 16;
  localparam int MAX_MACHINES    = 16;
  localparam int MAX_OPS_PER_JOB = 8;
  localparam int DURATION_WIDTH  = 10;

  localparam int JOB_W   = $clog2(MAX_JOBS);
  localparam int MACH_W  = $clog2(MAX_MACHINES);
  localparam int OP_W    = $clog2(MAX_OPS_PER_JOB);
  localparam int CNT_W   = $clog2(MAX_OPS_PER_JOB + 1);
  localparam int DUR_W   = 10;
  localparam int TIME_W  = 20;
  localparam int LOAD_W  = 24;
  localparam int ADDR_W  = JOB_W + OP_W + MACH_W;
  localparam int TABLE_DEPTH = MAX_JOBS * MAX_OPS_PER_JOB * MAX_MACHINES;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam logic [CNT_W-1:0]  OPS_FULL = CNT_W'(MAX_OPS_PER_JOB);
  localparam logic [DUR_W-1:0]  DUR_MASK = DUR_W'((1 << DURATION_WIDTH) - 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GENE = 1'b1
  } opcode_t;

endpackage

### sv/jsse_in_if.sv
// Interface: input channel carrying load and gene transactions.
interface jsse_in_if import jsse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [JOB_W-1:0]  job_index;
  logic [OP_W-1:0]   operation_index;
  logic [MACH_W-1:0] machine_index;
  logic [DUR_W-1:0]  duration;
  logic              last_gene;

  modport source (output valid, opcode, job_index, operation_index, machine_index,
                  duration, last_gene, input ready);
  modport sink   (input valid, opcode, job_index, operation_index, machine_index,
                  duration, last_gene, output ready);
endinterface

### sv/jsse_out_if.sv
// Interface: result channel carrying one score per chromosome.
interface jsse_out_if import jsse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] makespan;
  logic [LOAD_W-1:0] total_load;
  logic              sequence_error;

  modport source (output valid, makespan, total_load, sequence_error, input ready);
  modport sink   (input valid, makespan, total_load, sequence_error, output ready);
endinterface

### sv/job_shop_schedule_evaluator.sv
// Top level: flexible job-shop chromosome scorer with duration table memory.
//
//  channel | dir | handshake         | payload
//  in_if   | in  | valid/ready       | opcode, job, operation, machine, duration, last_gene
//  out_if  | out | valid/ready       | makespan, total_load, sequence_error
//
// One transaction per cycle sustained while no waiting result stalls input.
// A gene reads the duration memory at acceptance (op index from the job's
// count) into the stage 1 registers; the job/machine time update then works
// from those registers, at the same edge that loads the output register for a
// final gene. Reset clears counts, times and valids; the duration memory is not
// cleared. A waiting result stalls input only when a final gene is queued.
module job_shop_schedule_evaluator import jsse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  jsse_in_if.sink    in_if,
  jsse_out_if.source out_if
);

  // duration memory
  logic [DUR_W-1:0] dur_mem [TABLE_DEPTH];

  // stage 0: operation counts
  logic [CNT_W-1:0] op_cnt_r [MAX_JOBS];

  // stage 1: gene registers
  logic              s1_valid_r;
  logic              s1_last_r;
  logic              s1_skip_r;
  logic [JOB_W-1:0]  s1_job_r;
  logic [MACH_W-1:0] s1_mach_r;
  logic [DUR_W-1:0]  s1_dur_r;

  logic [TIME_W-1:0] job_rdy_r  [MAX_JOBS];
  logic [TIME_W-1:0] mach_rdy_r [MAX_MACHINES];
  logic [TIME_W-1:0] makespan_r;
  logic [LOAD_W-1:0] load_sum_r;
  logic              err_r;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_makespan_r;
  logic [LOAD_W-1:0] out_load_r;
  logic              out_err_r;

  logic              in_fire, gene_fire, load_fire, s1_fire;
  logic [CNT_W-1:0]  cur_cnt;
  logic              used_up;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic [TIME_W-1:0] old_mach, start_t, finish;
  logic [TIME_W:0]   finish_raw;
  logic [LOAD_W:0]   load_raw;
  logic [TIME_W-1:0] makespan_nxt;
  logic [LOAD_W-1:0] load_sum_nxt;
  logic              err_nxt;

  assign in_fire   = in_if.valid && in_if.ready;
  assign gene_fire = in_fire && (opcode_t'(in_if.opcode) == OP_GENE);
  assign load_fire = in_fire && (opcode_t'(in_if.opcode) == OP_LOAD);

  assign s1_fire     = s1_valid_r && (!s1_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_fire;

  assign cur_cnt = op_cnt_r[in_if.job_index];
  assign used_up = (cur_cnt == OPS_FULL);
  assign wr_addr = {in_if.job_index, in_if.operation_index, in_if.machine_index};
  assign rd_addr = {in_if.job_index, cur_cnt[OP_W-1:0], in_if.machine_index};

  always_ff @(posedge clk) begin
    if (load_fire) begin
      dur_mem[wr_addr] <= in_if.duration & DUR_MASK;
    end
    if (gene_fire) begin
      s1_dur_r <= dur_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOBS; j++) op_cnt_r[j] <= '0;
    end else if (gene_fire) begin
      if (in_if.last_gene) begin
        for (int j = 0; j < MAX_JOBS; j++) op_cnt_r[j] <= '0;
      end else if (!used_up) begin
        op_cnt_r[in_if.job_index] <= cur_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= gene_fire;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gene_fire) begin
      s1_last_r <= in_if.last_gene;
      s1_skip_r <= used_up;
      s1_job_r  <= in_if.job_index;
      s1_mach_r <= in_if.machine_index;
    end
  end

  // time update for the gene in stage 1
  always_comb begin
    old_mach   = mach_rdy_r[s1_mach_r];
    start_t    = (old_mach > job_rdy_r[s1_job_r]) ? old_mach : job_rdy_r[s1_job_r];
    finish_raw = {1'b0, start_t} + (TIME_W+1)'(s1_dur_r);
    finish     = finish_raw[TIME_W] ? TIME_MAX : finish_raw[TIME_W-1:0];
    // finish never drops below the machine's old ready time
    load_raw   = {1'b0, load_sum_r} + (LOAD_W+1)'(finish - old_mach);
    if (s1_skip_r) begin
      makespan_nxt = makespan_r;
      load_sum_nxt = load_sum_r;
      err_nxt      = 1'b1;
    end else begin
      makespan_nxt = (finish > makespan_r) ? finish : makespan_r;
      load_sum_nxt = load_raw[LOAD_W] ? LOAD_MAX : load_raw[LOAD_W-1:0];
      err_nxt      = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOBS; j++) job_rdy_r[j] <= '0;
      for (int m = 0; m < MAX_MACHINES; m++) mach_rdy_r[m] <= '0;
      makespan_r <= '0;
      load_sum_r <= '0;
      err_r      <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        for (int j = 0; j < MAX_JOBS; j++) job_rdy_r[j] <= '0;
        for (int m = 0; m < MAX_MACHINES; m++) mach_rdy_r[m] <= '0;
        makespan_r <= '0;
        load_sum_r <= '0;
        err_r      <= 1'b0;
      end else begin
        if (!s1_skip_r) begin
          job_rdy_r[s1_job_r]   <= finish;
          mach_rdy_r[s1_mach_r] <= finish;
        end
        makespan_r <= makespan_nxt;
        load_sum_r <= load_sum_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_makespan_r <= makespan_nxt;
      out_load_r     <= load_sum_nxt;
      out_err_r      <= err_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.makespan       = out_makespan_r;
  assign out_if.total_load     = out_load_r;
  assign out_if.sequence_error = out_err_r;

endmodule

### sv/jsse_checker.sv
// Checker: port-level assertions for the schedule evaluator, with its bind.
module jsse_checker import jsse_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TIME_W-1:0] makespan,
  input logic [LOAD_W-1:0] total_load,
  input logic              sequence_error
);

  // result channel empties during reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(makespan) && $stable(total_load)
      && $stable(sequence_error))
    else $error("stalled result changed");

  // the summed machine finish times cover the latest one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (LOAD_W'(makespan) <= total_load))
    else $error("makespan exceeds total load");

  // zero load means a zero makespan
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (total_load == '0) |-> (makespan == '0))
    else $error("nonzero makespan with zero load");

endmodule

bind job_shop_schedule_evaluator jsse_checker u_jsse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .makespan       (out_if.makespan),
  .total_load     (out_if.total_load),
  .sequence_error (out_if.sequence_error)
);
